/* hdl/evfpl_pkg.sv */
// ----------------------------------------------------------------------------
// evfpl_pkg
// shared constants, codes and types of the echo verified flash page loader
// ----------------------------------------------------------------------------
package evfpl_pkg;

   // page geometry
   localparam int PAGE_BYTES       = 64;
   localparam int PAGES_PER_SECTOR = 16;

   // field widths
   localparam int RX_W     = 8;
   localparam int KIND_W   = 2;
   localparam int DATA_W   = 32;
   localparam int PAGE_W   = 8;
   localparam int SECTOR_W = 4;
   localparam int ADDR_W   = 14;

   // derived sizes
   localparam int BIDX_W      = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
   localparam int STORE_WORDS = (PAGE_BYTES + 3) / 4;
   localparam int WIDX_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int PROG_WORDS  = PAGE_BYTES / 4;
   localparam int PROG_STEPS  = PROG_WORDS + 4;
   localparam int MAX_STEPS   = (PAGE_BYTES > PROG_STEPS) ? PAGE_BYTES : PROG_STEPS;
   localparam int STEP_W      = $clog2(MAX_STEPS);
   localparam int SUB_W       = (PAGES_PER_SECTOR > 1) ? $clog2(PAGES_PER_SECTOR) : 1;

   // job queue
   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

   // outstanding page store readers
   localparam int PEND_W = 2;

   localparam logic [DATA_W-1:0] ACK_DATA = DATA_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_TX    = 2'd0,
      KIND_PREP  = 2'd1,
      KIND_ERASE = 2'd2,
      KIND_PROG  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      JOB_ACK  = 2'd0,
      JOB_ECHO = 2'd1,
      JOB_PROG = 2'd2
   } job_kind_type;

   typedef enum logic [1:0] {
      SEL_CONST = 2'd0,
      SEL_BYTE  = 2'd1,
      SEL_WORD  = 2'd2
   } data_sel_type;

   typedef struct packed {
      job_kind_type          kind;
      logic [PAGE_W-1:0]     page;
      logic [SECTOR_W-1:0]   sector;
   } job_type;

   typedef struct packed {
      logic                en;
      logic [WIDX_W-1:0]   word;
      logic [1:0]          lane;
      logic [RX_W-1:0]     data;
   } store_wr_type;

   typedef struct packed {
      kind_type              kind;
      data_sel_type          sel;
      logic [1:0]            lane;
      logic [DATA_W-1:0]     cdata;
      logic [PAGE_W-1:0]     page;
      logic [SECTOR_W-1:0]   sector;
      logic [ADDR_W-1:0]     addr;
      logic                  last;
   } result_type;

endpackage

/* hdl/evfpl_if.sv */
// ----------------------------------------------------------------------------
// evfpl channel interfaces
// valid/ready channels for received bytes and for result transactions
// ----------------------------------------------------------------------------
interface evfpl_req_if import evfpl_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RX_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface evfpl_rsp_if import evfpl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [DATA_W-1:0]   data;
   logic [PAGE_W-1:0]   page;
   logic [SECTOR_W-1:0] sector;
   logic [ADDR_W-1:0]   flash_address;
   logic                last;

   modport source (output valid, output kind, output data, output page, output sector,
                   output flash_address, output last, input ready);
   modport sink   (input valid, input kind, input data, input page, input sector,
                   input flash_address, input last, output ready);
endinterface

/* hdl/evfpl_front.sv */
// ----------------------------------------------------------------------------
// evfpl_front
// accepts received bytes, tracks the protocol phase, fills the page store
// and posts jobs for the back end
// ----------------------------------------------------------------------------
module evfpl_front import evfpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   evfpl_req_if.sink     req_ch,
   input  logic          jobq_full,
   output logic          push_valid,
   output job_type       push_job,
   output store_wr_type  store_wr,
   input  logic          store_done
);

   typedef enum logic [3:0] {
      PH_COUNT   = 4'b0001,
      PH_DATA    = 4'b0010,
      PH_CONFIRM = 4'b0100,
      PH_DONE    = 4'b1000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [PAGE_W-1:0]     pages_total_ff, pages_total_in;
   logic [PAGE_W-1:0]     page_index_ff, page_index_in;
   logic [BIDX_W-1:0]     byte_index_ff, byte_index_in;
   logic [SUB_W-1:0]      sub_ff, sub_in;
   logic [SECTOR_W-1:0]   sector_ff, sector_in;
   logic [PEND_W-1:0]     pend_ff, pend_in;
   logic                  accept;
   logic                  push_store;
   logic [PAGE_W-1:0]     page_next;

   // page store may not be overwritten while a reader is still queued or active
   assign req_ch.ready = !jobq_full && !((phase_ff == PH_DATA) && (pend_ff != '0));
   assign accept       = req_ch.valid && req_ch.ready;
   assign page_next    = page_index_ff + PAGE_W'(1);

   always_comb begin
      phase_in       = phase_ff;
      pages_total_in = pages_total_ff;
      page_index_in  = page_index_ff;
      byte_index_in  = byte_index_ff;
      sub_in         = sub_ff;
      sector_in      = sector_ff;
      push_valid     = 1'b0;
      push_job       = '{kind: JOB_ACK, page: page_index_ff, sector: sector_ff};
      push_store     = 1'b0;
      store_wr.en    = 1'b0;
      store_wr.word  = WIDX_W'(byte_index_ff >> 2);
      store_wr.lane  = byte_index_ff[1:0];
      store_wr.data  = req_ch.rx_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_COUNT: begin
               pages_total_in = req_ch.rx_byte;
               page_index_in  = '0;
               byte_index_in  = '0;
               sub_in         = '0;
               sector_in      = '0;
               push_valid     = 1'b1;
               push_job.kind  = JOB_ACK;
               phase_in       = (req_ch.rx_byte == '0) ? PH_DONE : PH_DATA;
            end
            PH_DATA: begin
               store_wr.en = 1'b1;
               if (byte_index_ff == BIDX_W'(PAGE_BYTES - 1)) begin
                  push_valid    = 1'b1;
                  push_store    = 1'b1;
                  push_job.kind = JOB_ECHO;
                  byte_index_in = '0;
                  phase_in      = PH_CONFIRM;
               end else begin
                  byte_index_in = byte_index_ff + BIDX_W'(1);
               end
            end
            PH_CONFIRM: begin
               byte_index_in = '0;
               if (req_ch.rx_byte == '0) begin
                  // rejected page, collect it again
                  phase_in = PH_DATA;
               end else begin
                  push_valid    = 1'b1;
                  push_store    = 1'b1;
                  push_job.kind = JOB_PROG;
                  page_index_in = page_next;
                  if (sub_ff == SUB_W'(PAGES_PER_SECTOR - 1)) begin
                     sub_in    = '0;
                     sector_in = sector_ff + SECTOR_W'(1);
                  end else begin
                     sub_in = sub_ff + SUB_W'(1);
                  end
                  phase_in = (page_next >= pages_total_ff) ? PH_DONE : PH_DATA;
               end
            end
            PH_DONE: begin
            end
            default: begin
               phase_in = PH_COUNT;
            end
         endcase
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (push_store && !store_done) begin
         pend_in = pend_ff + PEND_W'(1);
      end else if (!push_store && store_done) begin
         pend_in = pend_ff - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_COUNT;
         pages_total_ff <= '0;
         page_index_ff  <= '0;
         byte_index_ff  <= '0;
         sub_ff         <= '0;
         sector_ff      <= '0;
         pend_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         pages_total_ff <= pages_total_in;
         page_index_ff  <= page_index_in;
         byte_index_ff  <= byte_index_in;
         sub_ff         <= sub_in;
         sector_ff      <= sector_in;
         pend_ff        <= pend_in;
      end
   end

   // store writes only when no reader is outstanding
   a_wr_no_reader: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> (pend_ff == '0))
      else $error("page store written while a reader is outstanding");

   // at most an echo and a program job can be outstanding
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != PEND_W'(3))
      else $error("outstanding reader count out of range");

endmodule

/* hdl/evfpl_jobq.sv */
// ----------------------------------------------------------------------------
// evfpl_jobq
// small job queue between front and back end
// ----------------------------------------------------------------------------
module evfpl_jobq import evfpl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  job_type  push_job,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop_ready,
   output job_type  pop_job
);

   job_type                 slot_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [JOBQ_CNT_W-1:0]   count_ff;
   logic                    do_push, do_pop;

   assign full      = (count_ff == JOBQ_CNT_W'(JOBQ_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + JOBQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + JOBQ_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + JOBQ_CNT_W'(1);
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - JOBQ_CNT_W'(1);
         end
      end
   end

   // the front end never posts into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("job posted into a full queue");

endmodule

/* hdl/evfpl_back.sv */
// ----------------------------------------------------------------------------
// evfpl_back
// page store and result sequencer: acknowledges, page echo and flash commands
// ----------------------------------------------------------------------------
module evfpl_back import evfpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  store_wr_type  store_wr,
   input  logic          job_valid,
   output logic          job_ready,
   input  job_type       job,
   output logic          store_done,
   evfpl_rsp_if.source   rsp_ch
);

   logic [DATA_W-1:0]     mem [STORE_WORDS];
   logic [DATA_W-1:0]     rd_ff;

   logic                  active_ff;
   job_type               job_ff;
   logic [STEP_W-1:0]     step_ff;

   logic                  s1_valid_ff;
   result_type            s1_ff;
   result_type            res;

   logic                  rsp_valid_ff;
   kind_type              rsp_kind_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [PAGE_W-1:0]     rsp_page_ff;
   logic [SECTOR_W-1:0]   rsp_sector_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;
   logic                  rsp_last_ff;

   logic                  issue, s1_move, final_step;
   logic [WIDX_W-1:0]     rd_addr;
   logic [STEP_W-1:0]     word_idx;
   logic [DATA_W-1:0]     out_data;

   assign job_ready  = !active_ff;
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign issue      = active_ff && (!s1_valid_ff || s1_move);
   assign store_done = issue && final_step && (job_ff.kind != JOB_ACK);
   assign word_idx   = step_ff - STEP_W'(3);

   // step decode
   always_comb begin
      res        = '{kind: KIND_TX, sel: SEL_CONST, lane: 2'd0, cdata: '0, page: '0,
                     sector: '0, addr: '0, last: 1'b0};
      rd_addr    = '0;
      final_step = 1'b0;
      unique case (job_ff.kind)
         JOB_ACK: begin
            res.cdata  = ACK_DATA;
            final_step = 1'b1;
         end
         JOB_ECHO: begin
            res.sel    = SEL_BYTE;
            res.lane   = step_ff[1:0];
            rd_addr    = WIDX_W'(step_ff >> 2);
            final_step = (step_ff == STEP_W'(PAGE_BYTES - 1));
         end
         JOB_PROG: begin
            if (step_ff == STEP_W'(0) || step_ff == STEP_W'(2)) begin
               res.kind   = KIND_PREP;
               res.sector = job_ff.sector;
            end else if (step_ff == STEP_W'(1)) begin
               res.kind = KIND_ERASE;
               res.page = job_ff.page;
            end else if (step_ff == STEP_W'(PROG_STEPS - 1)) begin
               res.cdata  = ACK_DATA;
               final_step = 1'b1;
            end else begin
               res.kind = KIND_PROG;
               res.sel  = SEL_WORD;
               res.page = job_ff.page;
               rd_addr  = WIDX_W'(word_idx);
               res.addr = ADDR_W'(int'(job_ff.page) * PAGE_BYTES + int'(word_idx) * 4);
            end
         end
         default: begin
            final_step = 1'b1;
         end
      endcase
      res.last = final_step;
   end

   // page store, byte lane writes and registered word read
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         mem[store_wr.word][8 * store_wr.lane +: 8] <= store_wr.data;
      end
      if (issue) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // job sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
      end else if (!active_ff) begin
         if (job_valid) begin
            active_ff <= 1'b1;
            step_ff   <= '0;
         end
      end else if (issue) begin
         if (final_step) begin
            active_ff <= 1'b0;
         end
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (!active_ff && job_valid) begin
         job_ff <= job;
      end
   end

   // decode stage, waits for the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (issue) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff <= res;
      end
   end

   always_comb begin
      case (s1_ff.sel)
         SEL_BYTE: out_data = DATA_W'(rd_ff[8 * s1_ff.lane +: 8]);
         SEL_WORD: out_data = rd_ff;
         default:  out_data = s1_ff.cdata;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_kind_ff   <= s1_ff.kind;
         rsp_data_ff   <= out_data;
         rsp_page_ff   <= s1_ff.page;
         rsp_sector_ff <= s1_ff.sector;
         rsp_addr_ff   <= s1_ff.addr;
         rsp_last_ff   <= s1_ff.last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = rsp_kind_ff;
   assign rsp_ch.data          = rsp_data_ff;
   assign rsp_ch.page          = rsp_page_ff;
   assign rsp_ch.sector        = rsp_sector_ff;
   assign rsp_ch.flash_address = rsp_addr_ff;
   assign rsp_ch.last          = rsp_last_ff;

   // a store reader finishes only from an active job
   a_done_active: assert property (@(posedge clock) disable iff (reset)
      store_done |-> active_ff)
      else $error("store release without an active job");

   // a decoded result always lands in the output register
   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("decoded result lost");

endmodule

/* hdl/echo_verified_flash_page_loader_core.sv */
// ----------------------------------------------------------------------------
// echo_verified_flash_page_loader_core
// serial page loader: echoes each received page, and once it is confirmed erases and programs it
// ----------------------------------------------------------------------------
// path: the first result of a transaction passes the job queue, the job sequencer,
// the decode stage and the output register
// throughput: one result per cycle within a job while the result side is ready
// a page echo gives 64 results, a confirmed page 20 results
// data bytes of the next page wait until the page store has been read out
// reset: synchronous, clears phase, counters, queue and handshakes;
// the page store has no clearing pass and holds stale data until written
// ----------------------------------------------------------------------------
module echo_verified_flash_page_loader_core import evfpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   evfpl_req_if.sink     req_ch,
   evfpl_rsp_if.source   rsp_ch
);

   // front to queue
   logic          push_valid;
   job_type       push_job;
   logic          jobq_full;

   // queue to back
   logic          job_valid;
   logic          job_ready;
   job_type       job;

   // page store write port and reader release
   store_wr_type  store_wr;
   logic          store_done;

   // front: byte classification, phase tracking and page store fill
   evfpl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .jobq_full  (jobq_full),
      .push_valid (push_valid),
      .push_job   (push_job),
      .store_wr   (store_wr),
      .store_done (store_done)
   );

   // queue decouples byte intake from result generation
   evfpl_jobq u_jobq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (jobq_full),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_job    (job)
   );

   // back: walks each job one result per cycle into the output register while the result side is ready
   evfpl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .store_done (store_done),
      .rsp_ch     (rsp_ch)
   );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench for the echo verified flash page loader: drives the serial bytes
// for a short multi-page load, predicts echoes, flash commands and acks, and
// checks every result transaction in order under random idling on both sides
// ----------------------------------------------------------------------------
module tb_top;
   import evfpl_pkg::*;

   // loader phases as tracked by the predictor
   typedef enum logic [1:0] {
      LD_COUNT   = 2'd0,
      LD_DATA    = 2'd1,
      LD_CONFIRM = 2'd2,
      LD_DONE    = 2'd3
   } load_phase_type;

   typedef struct packed {
      kind_type              kind;
      logic [DATA_W-1:0]     data;
      logic [PAGE_W-1:0]     page;
      logic [SECTOR_W-1:0]   sector;
      logic [ADDR_W-1:0]     addr;
      logic                  last;
   } flash_op_type;

   typedef struct {
      logic [RX_W-1:0] rx;
      bit              typed;
      flash_op_type    op;
   } stim_row_type;

   // pages announced by the count byte; small so the load reaches done
   localparam logic [RX_W-1:0] LOAD_PAGES  = 8'd4;
   localparam int              EDGE_COUNT  = 22;
   localparam int              IGNORED_MAX = 12;
   localparam int              MAX_SHOWN   = 10;

   // walking ones and zeros, extremes and checkerboards for the first page
   localparam logic [RX_W-1:0] EDGE_BYTES [EDGE_COUNT] = '{
      8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFE,
      8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h55, 8'hAA, 8'h0F, 8'hF0
   };

   logic clock;
   logic reset;

   evfpl_req_if req_bus ();
   evfpl_rsp_if rsp_bus ();

   echo_verified_flash_page_loader_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // predictor state
   load_phase_type     ld_phase;
   logic [PAGE_W-1:0]  ld_pages_total;
   logic [PAGE_W-1:0]  ld_page;
   int                 ld_byte_cnt;
   logic [RX_W-1:0]    ld_store [PAGE_BYTES];

   flash_op_type pending_flash_ops [$];
   int           error_count;
   bit           no_idle [2];   // 0 sender, 1 receiver
   int           send_gap;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #50000000;
      $display("Test completed with failures");
      $finish;
   end

   // cycles to wait before the next transaction, with stretches of no idling
   function automatic int pick_wait(input int side);
      if ($urandom_range(0, 39) == 0)
         no_idle[side] = !no_idle[side];
      return no_idle[side] ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic flash_op_type make_op(input kind_type k, input logic [DATA_W-1:0] d,
                                            input logic [PAGE_W-1:0] pg,
                                            input logic [SECTOR_W-1:0] sec,
                                            input logic [ADDR_W-1:0] a);
      flash_op_type op;
      op.kind   = k;
      op.data   = d;
      op.page   = pg;
      op.sector = sec;
      op.addr   = a;
      op.last   = 1'b0;
      return op;
   endfunction

   // advance the loader by one received byte and queue the results it causes
   task automatic predict_flash_ops(input logic [RX_W-1:0] b, input bit keep);
      flash_op_type        ops [$];
      logic [SECTOR_W-1:0] sec;
      case (ld_phase)
         LD_COUNT: begin
            ld_pages_total = b;
            ld_page        = '0;
            ld_byte_cnt    = 0;
            ops.push_back(make_op(KIND_TX, ACK_DATA, '0, '0, '0));
            ld_phase = (b == 0) ? LD_DONE : LD_DATA;
         end
         LD_DATA: begin
            ld_store[ld_byte_cnt] = b;
            ld_byte_cnt++;
            if (ld_byte_cnt == PAGE_BYTES) begin
               // full page: echo every stored byte
               for (int i = 0; i < PAGE_BYTES; i++)
                  ops.push_back(make_op(KIND_TX, DATA_W'(ld_store[i]), '0, '0, '0));
               ld_byte_cnt = 0;
               ld_phase    = LD_CONFIRM;
            end
         end
         LD_CONFIRM: begin
            if (b == 0) begin
               // rejected page, collect it again
               ld_phase    = LD_DATA;
               ld_byte_cnt = 0;
            end else begin
               sec = SECTOR_W'(int'(ld_page) / PAGES_PER_SECTOR);
               ops.push_back(make_op(KIND_PREP, '0, '0, sec, '0));
               ops.push_back(make_op(KIND_ERASE, '0, ld_page, '0, '0));
               ops.push_back(make_op(KIND_PREP, '0, '0, sec, '0));
               for (int i = 0; i + 3 < PAGE_BYTES; i += 4)
                  ops.push_back(make_op(KIND_PROG,
                                        {ld_store[i+3], ld_store[i+2],
                                         ld_store[i+1], ld_store[i]},
                                        ld_page, '0,
                                        ADDR_W'(int'(ld_page) * PAGE_BYTES + i)));
               ops.push_back(make_op(KIND_TX, ACK_DATA, '0, '0, '0));
               ld_page     = ld_page + PAGE_W'(1);
               ld_byte_cnt = 0;
               ld_phase    = (ld_page >= ld_pages_total) ? LD_DONE : LD_DATA;
            end
         end
         default: ;   // done: bytes are ignored
      endcase
      if (ops.size() > 0)
         ops[ops.size()-1].last = 1'b1;
      if (keep)
         foreach (ops[k])
            pending_flash_ops.push_back(ops[k]);
   endtask

   // one byte transaction; valid stays high across back-to-back transactions
   task automatic send_byte(input logic [RX_W-1:0] b, input bit typed,
                            input flash_op_type op);
      if (send_gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (send_gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_flash_ops(b, !typed);
      if (typed)
         pending_flash_ops.push_back(op);
      send_gap = pick_wait(0);
   endtask

   task automatic check_flash_op();
      flash_op_type want;
      if (pending_flash_ops.size() == 0) begin
         error_count++;
         if (error_count <= MAX_SHOWN)
            $display("unexpected result: kind=%0d data=%h page=%0d sector=%0d addr=%0d last=%0d",
                     rsp_bus.kind, rsp_bus.data, rsp_bus.page, rsp_bus.sector,
                     rsp_bus.flash_address, rsp_bus.last);
      end else begin
         want = pending_flash_ops.pop_front();
         if (want.kind !== rsp_bus.kind || want.data !== rsp_bus.data ||
             want.page !== rsp_bus.page || want.sector !== rsp_bus.sector ||
             want.addr !== rsp_bus.flash_address || want.last !== rsp_bus.last) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
               $display("mismatch exp: kind=%0d data=%h page=%0d sector=%0d addr=%0d last=%0d",
                        want.kind, want.data, want.page, want.sector, want.addr, want.last);
               $display("         got: kind=%0d data=%h page=%0d sector=%0d addr=%0d last=%0d",
                        rsp_bus.kind, rsp_bus.data, rsp_bus.page, rsp_bus.sector,
                        rsp_bus.flash_address, rsp_bus.last);
            end
         end
      end
   endtask

   // result side: random stalls on ready, check every accepted transaction
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_wait(1);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         check_flash_op();
      end
   end

   // stimulus and end of run
   initial begin
      stim_row_type      directed_rows [EDGE_COUNT + 1];
      logic [RX_W-1:0]   b;
      logic [PAGE_W-1:0] rej_page;
      int                rejects;
      int                ignored;
      bit                reject;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      error_count     = 0;
      send_gap        = 0;
      ld_phase        = LD_COUNT;
      ld_pages_total  = '0;
      ld_page         = '0;
      ld_byte_cnt     = 0;
      rej_page        = '0;
      rejects         = 0;
      ignored         = 0;

      // count byte first, its ack is known up front
      directed_rows[0].rx    = LOAD_PAGES;
      directed_rows[0].typed = 1'b1;
      directed_rows[0].op    = '{kind: KIND_TX, data: ACK_DATA, page: '0, sector: '0,
                                 addr: '0, last: 1'b1};
      // then the head of the first page, echoed later through the predictor
      for (int i = 0; i < EDGE_COUNT; i++) begin
         directed_rows[i+1].rx    = EDGE_BYTES[i];
         directed_rows[i+1].typed = 1'b0;
         directed_rows[i+1].op    = '0;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r])
         send_byte(directed_rows[r].rx, directed_rows[r].typed, directed_rows[r].op);

      // random part follows the loader: page data, confirmations, then noise
      while (ignored < IGNORED_MAX) begin
         case (ld_phase)
            LD_DATA: begin
               if ($urandom_range(0, 7) == 0)
                  b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               else
                  b = 8'($urandom_range(0, 255));
            end
            LD_CONFIRM: begin
               if (ld_page != rej_page) begin
                  rej_page = ld_page;
                  rejects  = 0;
               end
               // first page always rejected at least once, later ones now and then
               reject = (ld_page == 0 && rejects == 0) ||
                        (rejects < 2 && $urandom_range(0, 3) == 0);
               if (reject) begin
                  b = 8'h00;
                  rejects++;
               end else if (ld_page == 0)
                  b = 8'hFF;
               else if (ld_page == 1)
                  b = 8'h01;
               else
                  b = 8'($urandom_range(1, 255));
            end
            default: begin
               // after the last page nothing should come out
               b = 8'($urandom_range(0, 255));
               ignored++;
            end
         endcase
         send_byte(b, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      // drain, then a quiet window to catch stray results
      while (pending_flash_ops.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
